[rtl/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check, muted while reset is asserted
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check that also runs through reset
`define CHK_ASSERT_RST(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

[rtl/bmct_pkg.sv]
`default_nettype none

package bmct_pkg;

  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int LAT_W      = MAX_WIDTH + 1;
  localparam int LAT_H      = MAX_HEIGHT + 1;
  localparam int MAX_DIM    = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  // one spare bit so that a coordinate minus one wraps far above any bound
  localparam int COORD_W    = $clog2(MAX_DIM + 2) + 1;
  localparam int MSK_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int MSK_AW     = $clog2(MSK_DEPTH);
  localparam int VIS_DEPTH  = LAT_W * LAT_H;
  localparam int VIS_AW     = $clog2(VIS_DEPTH);

  localparam logic [1:0] FN_WRITE = 2'd0;
  localparam logic [1:0] FN_START = 2'd1;
  localparam logic [1:0] FN_STEP  = 2'd2;

  localparam logic [1:0] REG_MARK   = 2'd0;
  localparam logic [1:0] REG_WIDTH  = 2'd1;
  localparam logic [1:0] REG_HEIGHT = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] pixel_x;
    logic [7:0] pixel_y;
    logic [7:0] pixel_value;
  } in_item_t;

  typedef struct packed {
    logic [8:0] point_x;
    logic [8:0] point_y;
    logic       found;
    logic       is_start;
  } out_item_t;

  typedef struct packed {
    logic              re;
    logic [MSK_AW-1:0] addr;
  } msk_rd_t;

  typedef struct packed {
    logic              clr_go;
    logic              we;
    logic [VIS_AW-1:0] waddr;
    logic              re;
    logic [VIS_AW-1:0] raddr;
  } vis_ctl_t;

  function automatic coord_t eff_size(input logic [8:0] v, input int unsigned maxv);
    coord_t r;
    if (v == 9'd0) begin
      r = COORD_W'(1);
    end else if (32'(v) > 32'(maxv)) begin
      r = COORD_W'(maxv);
    end else begin
      r = COORD_W'(v);
    end
    return r;
  endfunction

  function automatic logic [MSK_AW-1:0] mask_addr(input coord_t x, input coord_t y);
    return MSK_AW'(MSK_AW'(y) * MSK_AW'(MAX_WIDTH) + MSK_AW'(x));
  endfunction

  function automatic logic [VIS_AW-1:0] vis_addr(input coord_t x, input coord_t y);
    return VIS_AW'(VIS_AW'(y) * VIS_AW'(LAT_W) + VIS_AW'(x));
  endfunction

  function automatic logic in_img(input coord_t x, input coord_t y,
                                  input coord_t w, input coord_t h);
    return (x < w) && (y < h);
  endfunction

  function automatic logic in_lat(input coord_t x, input coord_t y);
    return (x < COORD_W'(LAT_W)) && (y < COORD_W'(LAT_H));
  endfunction

endpackage

`default_nettype wire

[rtl/bmct_mask.sv]
`default_nettype none

module bmct_mask (
  input  wire logic               clk,
  input  wire logic               wr_go,
  input  wire bmct_pkg::in_item_t wr_item,
  input  wire logic [7:0]         fg_code,
  input  wire bmct_pkg::msk_rd_t  rd,
  output logic                    rd_bit
);

  logic                        mem [bmct_pkg::MSK_DEPTH];
  logic                        rd_bit_r;
  logic                        wr_ok;
  logic [bmct_pkg::MSK_AW-1:0] waddr;

  // writes beyond the storage are dropped
  assign wr_ok = wr_go
              && (32'(wr_item.pixel_x) < 32'(bmct_pkg::MAX_WIDTH))
              && (32'(wr_item.pixel_y) < 32'(bmct_pkg::MAX_HEIGHT));
  assign waddr = bmct_pkg::mask_addr(bmct_pkg::COORD_W'(wr_item.pixel_x),
                                     bmct_pkg::COORD_W'(wr_item.pixel_y));

  always_ff @(posedge clk) begin
    if (wr_ok) begin
      mem[waddr] <= (wr_item.pixel_value == fg_code);
    end
    if (rd.re) begin
      rd_bit_r <= mem[rd.addr];
    end
  end

  assign rd_bit = rd_bit_r;

endmodule

`default_nettype wire

[rtl/bmct_visit.sv]
`default_nettype none

module bmct_visit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire bmct_pkg::vis_ctl_t ctl,
  output logic                    rd_bit,
  output logic                    clr_busy
);

  logic                        mem [bmct_pkg::VIS_DEPTH];
  logic                        rd_bit_r;
  logic                        clr_busy_r;
  logic [bmct_pkg::VIS_AW-1:0] clr_cnt_r;
  logic                        wen;
  logic [bmct_pkg::VIS_AW-1:0] wa;

  // the clearing sweep owns the write port while it runs
  assign wen = clr_busy_r || ctl.we;
  assign wa  = clr_busy_r ? clr_cnt_r : ctl.waddr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b0;
      clr_cnt_r  <= '0;
    end else if (ctl.clr_go) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
    end else if (clr_busy_r) begin
      clr_cnt_r <= clr_cnt_r + bmct_pkg::VIS_AW'(1);
      if (clr_cnt_r == bmct_pkg::VIS_AW'(bmct_pkg::VIS_DEPTH - 1)) begin
        clr_busy_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (wen) begin
      mem[wa] <= !clr_busy_r;
    end
    if (ctl.re) begin
      rd_bit_r <= mem[ctl.raddr];
    end
  end

  assign rd_bit   = rd_bit_r;
  assign clr_busy = clr_busy_r;

endmodule

`default_nettype wire

[rtl/bmct_seq.sv]
`default_nettype none

module bmct_seq (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire bmct_pkg::in_item_t  in_item,
  input  wire bmct_pkg::coord_t    w_use,
  input  wire bmct_pkg::coord_t    h_use,
  output logic                     busy,
  output bmct_pkg::msk_rd_t        msk_rd,
  input  wire logic                mask_bit,
  output bmct_pkg::vis_ctl_t       vis_ctl,
  input  wire logic                vis_bit,
  input  wire logic                clr_busy,
  output logic                     out_strobe,
  output bmct_pkg::out_item_t      out_item
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_SCAN = 2'd1;
  localparam logic [1:0] S_RD   = 2'd2;
  localparam logic [1:0] S_DEC  = 2'd3;

  logic [1:0]          state_r, state_nxt;
  bmct_pkg::coord_t    cur_x_r, cur_y_r;
  logic                active_r;
  logic [1:0]          ph_r;
  bmct_pkg::coord_t    sx_r, sy_r;
  logic                scan_end_r;
  logic                pend_r;
  bmct_pkg::coord_t    pend_x_r, pend_y_r;
  logic                hit_r;
  bmct_pkg::coord_t    hit_x_r, hit_y_r;
  logic [3:0]          pok_r, tok_r;
  logic [2:0]          pbit_r, vbit_r;
  logic                out_strobe_r;
  bmct_pkg::out_item_t out_item_r;

  logic                accept;
  logic                scan_issue, hit_now, scan_fin;
  bmct_pkg::coord_t    xm1, xp1, ym1, yp1;
  bmct_pkg::coord_t    mx, my, tx, ty;
  logic                m_ok, t_ok;
  logic                pa, pb, pc, pd;
  logic                s0, s1, s2, s3;
  logic                mv_l, mv_r, mv_u, mv_d, mv_any;
  bmct_pkg::coord_t    nx, ny;

  assign accept = start && !busy;
  assign busy   = (state_r != S_IDLE);

  assign xm1 = cur_x_r - bmct_pkg::COORD_W'(1);
  assign xp1 = cur_x_r + bmct_pkg::COORD_W'(1);
  assign ym1 = cur_y_r - bmct_pkg::COORD_W'(1);
  assign yp1 = cur_y_r + bmct_pkg::COORD_W'(1);

  // phase k reads mask pixel k and the visited bit of move target k
  always_comb begin
    case (ph_r)
      2'd0: begin mx = xm1;     my = cur_y_r; tx = xm1;     ty = cur_y_r; end
      2'd1: begin mx = xm1;     my = ym1;     tx = xp1;     ty = cur_y_r; end
      2'd2: begin mx = cur_x_r; my = ym1;     tx = cur_x_r; ty = ym1;     end
      default: begin mx = cur_x_r; my = cur_y_r; tx = cur_x_r; ty = yp1; end
    endcase
  end

  assign m_ok = bmct_pkg::in_img(mx, my, w_use, h_use);
  assign t_ok = bmct_pkg::in_lat(tx, ty);

  assign scan_issue = !hit_r && !scan_end_r;
  assign hit_now    = (state_r == S_SCAN) && pend_r && mask_bit && !hit_r;
  assign scan_fin   = (hit_r || (scan_end_r && !pend_r)) && !clr_busy;

  always_comb begin
    msk_rd.re   = ((state_r == S_SCAN) && scan_issue) || ((state_r == S_RD) && m_ok);
    msk_rd.addr = (state_r == S_SCAN) ? bmct_pkg::mask_addr(sx_r, sy_r)
                                      : bmct_pkg::mask_addr(mx, my);
  end

  // last pixel and target arrive straight from the memories
  assign pa = pbit_r[0];
  assign pb = pbit_r[1];
  assign pc = pbit_r[2];
  assign pd = mask_bit && pok_r[3];
  assign s0 = !tok_r[0] || vbit_r[0];
  assign s1 = !tok_r[1] || vbit_r[1];
  assign s2 = !tok_r[2] || vbit_r[2];
  assign s3 = !tok_r[3] || vis_bit;

  assign mv_l   = pa && !pb && !s0;
  assign mv_r   = pc && !pd && !s1;
  assign mv_u   = pb && !pc && !s2;
  assign mv_d   = !pa && pd && !s3;
  assign mv_any = mv_l || mv_r || mv_u || mv_d;

  always_comb begin
    if (mv_l) begin
      nx = xm1;     ny = cur_y_r;
    end else if (mv_r) begin
      nx = xp1;     ny = cur_y_r;
    end else if (mv_u) begin
      nx = cur_x_r; ny = ym1;
    end else begin
      nx = cur_x_r; ny = yp1;
    end
  end

  always_comb begin
    vis_ctl.clr_go = accept && (in_item.func == bmct_pkg::FN_START);
    vis_ctl.we     = (state_r == S_DEC) && mv_any;
    vis_ctl.waddr  = bmct_pkg::vis_addr(nx, ny);
    vis_ctl.re     = (state_r == S_RD) && t_ok;
    vis_ctl.raddr  = bmct_pkg::vis_addr(tx, ty);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && (in_item.func == bmct_pkg::FN_START)) begin
          state_nxt = S_SCAN;
        end else if (accept && (in_item.func == bmct_pkg::FN_STEP) && active_r) begin
          state_nxt = S_RD;
        end
      end
      S_SCAN: if (scan_fin) state_nxt = S_IDLE;
      S_RD:   if (ph_r == 2'd3) state_nxt = S_DEC;
      S_DEC:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      active_r     <= 1'b0;
      cur_x_r      <= '0;
      cur_y_r      <= '0;
      ph_r         <= 2'd0;
      scan_end_r   <= 1'b0;
      pend_r       <= 1'b0;
      hit_r        <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      out_strobe_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (accept && (in_item.func == bmct_pkg::FN_START)) begin
            sx_r       <= '0;
            sy_r       <= '0;
            scan_end_r <= 1'b0;
            pend_r     <= 1'b0;
            hit_r      <= 1'b0;
          end else if (accept && (in_item.func == bmct_pkg::FN_STEP)) begin
            ph_r <= 2'd0;
            if (!active_r) begin
              out_strobe_r <= 1'b1;
              out_item_r   <= '0;
            end
          end
        end
        S_SCAN: begin
          pend_r   <= scan_issue;
          pend_x_r <= sx_r;
          pend_y_r <= sy_r;
          if (scan_issue) begin
            if (sx_r == w_use - bmct_pkg::COORD_W'(1)) begin
              sx_r <= '0;
              if (sy_r == h_use - bmct_pkg::COORD_W'(1)) begin
                scan_end_r <= 1'b1;
              end else begin
                sy_r <= sy_r + bmct_pkg::COORD_W'(1);
              end
            end else begin
              sx_r <= sx_r + bmct_pkg::COORD_W'(1);
            end
          end
          if (hit_now) begin
            hit_r   <= 1'b1;
            hit_x_r <= pend_x_r;
            hit_y_r <= pend_y_r;
          end
          if (scan_fin) begin
            out_strobe_r <= 1'b1;
            active_r     <= hit_r;
            if (hit_r) begin
              cur_x_r             <= hit_x_r;
              cur_y_r             <= hit_y_r;
              out_item_r.point_x  <= 9'(hit_x_r);
              out_item_r.point_y  <= 9'(hit_y_r);
              out_item_r.found    <= 1'b1;
              out_item_r.is_start <= 1'b1;
            end else begin
              out_item_r <= '0;
            end
          end
        end
        S_RD: begin
          pok_r[ph_r] <= m_ok;
          tok_r[ph_r] <= t_ok;
          if (ph_r != 2'd0) begin
            pbit_r[ph_r - 2'd1] <= mask_bit && pok_r[ph_r - 2'd1];
            vbit_r[ph_r - 2'd1] <= vis_bit;
          end
          ph_r <= ph_r + 2'd1;
        end
        S_DEC: begin
          out_strobe_r <= 1'b1;
          if (mv_any) begin
            cur_x_r             <= nx;
            cur_y_r             <= ny;
            out_item_r.point_x  <= 9'(nx);
            out_item_r.point_y  <= 9'(ny);
            out_item_r.found    <= 1'b1;
            out_item_r.is_start <= 1'b0;
          end else begin
            active_r   <= 1'b0;
            out_item_r <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

endmodule

`default_nettype wire

[rtl/binary_mask_contour_tracer.sv]
// channel   direction  handshake                 payload
// in_       input      start high, busy low      in_data (func, pixel_x, pixel_y, pixel_value)
// out_      output     out_strobe, one cycle     out_data (point_x, point_y, found, is_start)
// cfg_      input      cfg_we                    cfg_index, cfg_data
//
// a pixel write leaves busy low; func 3 is dropped the same way
// a trace step keeps busy high through four mask reads through the single mask
// read port, then the decision; the result strobes in the same cycle that busy falls
// a step with no trace running strobes its result in the next cycle without busy
// a start keeps busy high until the 257 x 257 visited-map clearing sweep ends,
// one entry a cycle, which also covers the longest raster scan of the mask
// reset is synchronous and needs no clearing pass; results cannot be stalled

`default_nettype none

module binary_mask_contour_tracer (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                start,
  input  wire bmct_pkg::in_item_t  in_data,
  output logic                     busy,
  output logic                     out_strobe,
  output bmct_pkg::out_item_t      out_data,
  input  wire logic                cfg_we,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [8:0]          cfg_data
);

  logic [7:0]         mark_r;
  logic [8:0]         width_r;
  logic [8:0]         height_r;
  bmct_pkg::coord_t   w_use, h_use;
  logic               wr_go;
  bmct_pkg::msk_rd_t  msk_rd;
  bmct_pkg::vis_ctl_t vis_ctl;
  logic               mask_bit, vis_bit, clr_busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mark_r   <= 8'd1;
      width_r  <= 9'd256;
      height_r <= 9'd256;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bmct_pkg::REG_MARK:   mark_r   <= cfg_data[7:0];
        bmct_pkg::REG_WIDTH:  width_r  <= cfg_data;
        bmct_pkg::REG_HEIGHT: height_r <= cfg_data;
        default: ;
      endcase
    end
  end

  assign w_use = bmct_pkg::eff_size(width_r, bmct_pkg::MAX_WIDTH);
  assign h_use = bmct_pkg::eff_size(height_r, bmct_pkg::MAX_HEIGHT);
  assign wr_go = start && !busy && (in_data.func == bmct_pkg::FN_WRITE);

  bmct_mask u_mask (
    .clk        (clk),
    .wr_go      (wr_go),
    .wr_item    (in_data),
    .fg_code    (mark_r),
    .rd         (msk_rd),
    .rd_bit     (mask_bit)
  );

  bmct_visit u_visit (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (vis_ctl),
    .rd_bit   (vis_bit),
    .clr_busy (clr_busy)
  );

  bmct_seq u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_item    (in_data),
    .w_use      (w_use),
    .h_use      (h_use),
    .busy       (busy),
    .msk_rd     (msk_rd),
    .mask_bit   (mask_bit),
    .vis_ctl    (vis_ctl),
    .vis_bit    (vis_bit),
    .clr_busy   (clr_busy),
    .out_strobe (out_strobe),
    .out_item   (out_data)
  );

endmodule

`default_nettype wire

[rtl/bmct_checker.sv]
`default_nettype none

`include "assert_macros.svh"

module bmct_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                start,
  input wire logic                busy,
  input wire bmct_pkg::in_item_t  in_data,
  input wire logic                out_strobe,
  input wire bmct_pkg::out_item_t out_data
);

  `CHK_ASSERT_RST(a_reset_idle, clk, !rst_n |=> !busy && !out_strobe, "not idle after reset")

  `CHK_ASSERT(a_write_silent, clk, rst_n, start && !busy && in_data.func == bmct_pkg::FN_WRITE |=> !busy && !out_strobe, "pixel write caused busy or a result")

  `CHK_ASSERT(a_trace_reacts, clk, rst_n, start && !busy && (in_data.func == bmct_pkg::FN_START || in_data.func == bmct_pkg::FN_STEP) |=> busy || out_strobe, "trace item ignored")

  `CHK_ASSERT(a_result_idle, clk, rst_n, out_strobe |-> !busy, "result while busy")

  `CHK_ASSERT(a_miss_zero, clk, rst_n, out_strobe && !out_data.found |-> !out_data.is_start && out_data.point_x == 9'd0 && out_data.point_y == 9'd0, "miss result not cleared")

endmodule

bind binary_mask_contour_tracer bmct_checker u_bmct_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .in_data    (in_data),
  .out_strobe (out_strobe),
  .out_data   (out_data)
);

`default_nettype wire
